// File: rtl/tds_pkg.sv
// Package for the triangle depth sorter: sizes, word types, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tds_pkg;

	localparam int MAX_TRIANGLES = 64;
	localparam int COORD_BITS    = 32;
	localparam int KEY_BITS      = COORD_BITS + 2;
	localparam int ADDR_W        = $clog2(MAX_TRIANGLES);
	localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [KEY_BITS-1:0]   key_t;

	typedef struct packed {
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
		logic   batch_end;
	} tri_in_t;

	typedef struct packed {
		coord_t out_v0_x;
		coord_t out_v0_y;
		coord_t out_v0_z;
		coord_t out_v1_x;
		coord_t out_v1_y;
		coord_t out_v1_z;
		coord_t out_v2_x;
		coord_t out_v2_y;
		coord_t out_v2_z;
		logic   final_of_run;
		logic   overflowed;
	} tri_out_t;

	// One stored triangle with its depth key
	typedef struct packed {
		key_t   key;
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_DECIDE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;      // capture incoming word, pos := count
		logic set_ovf;   // store full: drop word, note overflow
		logic probe_rd;  // read entry pos-1
		logic shift;     // move read entry up to pos, pos--
		logic place;     // write new entry at pos, count++
		logic emit_rd;   // read entry idx for output, idx++
		logic emit_last; // this emit read is the final one
	} cmd_t;

	typedef struct packed {
		logic full;
		logic in_batch_end;
		logic batch_end;
		logic pos_zero;
		logic key_greater;
		logic idx_last;
	} status_t;

endpackage

// File: rtl/tds_ctrl.sv
// Controller for the triangle depth sorter: insertion and emission sequencing.
// Depends on tds_pkg.
`timescale 1ns / 1ps

module tds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tds_pkg::status_t  status,
	output tds_pkg::cmd_t     cmd,
	output logic              busy
);

	tds_pkg::state_t state_q;
	tds_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tds_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tds_pkg::S_IDLE: begin
				if (start) begin
					if (!status.full) begin
						state_d = tds_pkg::S_PROBE;
					end else if (status.in_batch_end) begin
						state_d = tds_pkg::S_EMIT;
					end
				end
			end
			tds_pkg::S_PROBE: begin
				if (status.pos_zero) begin
					state_d = status.batch_end ? tds_pkg::S_EMIT : tds_pkg::S_IDLE;
				end else begin
					state_d = tds_pkg::S_DECIDE;
				end
			end
			tds_pkg::S_DECIDE: begin
				if (status.key_greater) begin
					state_d = tds_pkg::S_PROBE;
				end else begin
					state_d = status.batch_end ? tds_pkg::S_EMIT : tds_pkg::S_IDLE;
				end
			end
			tds_pkg::S_EMIT: begin
				if (status.idx_last) begin
					state_d = tds_pkg::S_IDLE;
				end
			end
			default: state_d = tds_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != tds_pkg::S_IDLE);
		case (state_q)
			tds_pkg::S_IDLE: begin
				cmd.load    = start;
				cmd.set_ovf = start && status.full;
			end
			tds_pkg::S_PROBE: begin
				cmd.place    = status.pos_zero;
				cmd.probe_rd = !status.pos_zero;
			end
			tds_pkg::S_DECIDE: begin
				cmd.shift = status.key_greater;
				cmd.place = !status.key_greater;
			end
			tds_pkg::S_EMIT: begin
				cmd.emit_rd   = 1'b1;
				cmd.emit_last = status.idx_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/tds_datapath.sv
// Datapath for the triangle depth sorter: key adder, sorted store memory,
// insertion pointer, fill count and output register. Depends on tds_pkg.
`timescale 1ns / 1ps

module tds_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tds_pkg::tri_in_t   triangle,
	input  tds_pkg::cmd_t      cmd,
	output tds_pkg::status_t   status,
	output tds_pkg::tri_out_t  result,
	output logic               strobe
);

	tds_pkg::entry_t mem_q [tds_pkg::MAX_TRIANGLES];

	tds_pkg::entry_t                  new_q;
	logic                             batch_end_q;
	tds_pkg::entry_t                  rd_q;
	logic [tds_pkg::CNT_W-1:0]        count_q;
	logic [tds_pkg::CNT_W-1:0]        pos_q;
	logic [tds_pkg::ADDR_W-1:0]       idx_q;
	logic                             ovf_q;
	logic                             strobe_q;
	logic                             final_q;
	logic                             ovf_out_q;

	tds_pkg::key_t                    key_in;
	logic [tds_pkg::CNT_W-1:0]        pos_dec;
	logic [tds_pkg::ADDR_W-1:0]       wr_addr;
	logic [tds_pkg::ADDR_W-1:0]       rd_addr;
	tds_pkg::entry_t                  wr_data;
	logic                             wr_en;
	logic                             rd_en;

	// Sum of the three depths orders exactly as their average
	assign key_in = tds_pkg::KEY_BITS'(triangle.v0_z)
		+ tds_pkg::KEY_BITS'(triangle.v1_z)
		+ tds_pkg::KEY_BITS'(triangle.v2_z);

	assign pos_dec = pos_q - tds_pkg::CNT_W'(1);
	assign wr_addr = pos_q[tds_pkg::ADDR_W-1:0];
	assign wr_en   = cmd.place || cmd.shift;
	assign wr_data = cmd.shift ? rd_q : new_q;
	assign rd_en   = cmd.probe_rd || cmd.emit_rd;
	assign rd_addr = cmd.emit_rd ? idx_q : pos_dec[tds_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.key   <= key_in;
			new_q.v0_x  <= triangle.v0_x;
			new_q.v0_y  <= triangle.v0_y;
			new_q.v0_z  <= triangle.v0_z;
			new_q.v1_x  <= triangle.v1_x;
			new_q.v1_y  <= triangle.v1_y;
			new_q.v1_z  <= triangle.v1_z;
			new_q.v2_x  <= triangle.v2_x;
			new_q.v2_y  <= triangle.v2_y;
			new_q.v2_z  <= triangle.v2_z;
			batch_end_q <= triangle.batch_end;
		end
		if (cmd.emit_rd) begin
			final_q   <= cmd.emit_last;
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_rd;
			if (cmd.load) begin
				pos_q <= count_q;
				idx_q <= '0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.shift) begin
				pos_q <= pos_dec;
			end
			if (cmd.place) begin
				count_q <= count_q + tds_pkg::CNT_W'(1);
			end
			if (cmd.emit_rd) begin
				idx_q <= idx_q + tds_pkg::ADDR_W'(1);
			end
			// Batch delivered: start afresh
			if (cmd.emit_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign status.full         = (count_q == tds_pkg::CNT_W'(tds_pkg::MAX_TRIANGLES));
	assign status.in_batch_end = triangle.batch_end;
	assign status.batch_end    = batch_end_q;
	assign status.pos_zero     = (pos_q == '0);
	assign status.key_greater  = ($signed(rd_q.key) > $signed(new_q.key));
	assign status.idx_last     = ({1'b0, idx_q} == (count_q - tds_pkg::CNT_W'(1)));

	assign result.out_v0_x     = rd_q.v0_x;
	assign result.out_v0_y     = rd_q.v0_y;
	assign result.out_v0_z     = rd_q.v0_z;
	assign result.out_v1_x     = rd_q.v1_x;
	assign result.out_v1_y     = rd_q.v1_y;
	assign result.out_v1_z     = rd_q.v1_z;
	assign result.out_v2_x     = rd_q.v2_x;
	assign result.out_v2_y     = rd_q.v2_y;
	assign result.out_v2_z     = rd_q.v2_z;
	assign result.final_of_run = final_q;
	assign result.overflowed   = ovf_out_q;
	assign strobe              = strobe_q;

endmodule

// File: rtl/triangle_depth_sorter.sv
// Top level of the triangle depth sorter: controller plus datapath.
// Depends on tds_pkg, tds_ctrl and tds_datapath.
`timescale 1ns / 1ps

// Loads triangles one word per start pulse (taken when busy is low) and keeps
// them in a 64-entry store sorted by the sum of their three depths, a new word
// going after every stored one of equal or smaller key. Insertion walks the
// store one entry at a time through its single read and write port: busy
// stays high while each stored entry of larger key is moved up and the new
// word is placed, and the next word can be taken once busy is low again; a
// word that meets a full store is dropped and flagged, raising busy only if
// it carries batch_end.
// A word with batch_end then streams the whole batch out, one result per cycle,
// each shown on result for one cycle with strobe high, the output appearing in
// the cycle after its memory read. The receiver cannot stall; results are lost
// if not taken the cycle they appear.
module triangle_depth_sorter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tds_pkg::tri_in_t   triangle,
	output logic               busy,
	output tds_pkg::tri_out_t  result,
	output logic               strobe
);

	tds_pkg::cmd_t    cmd;
	tds_pkg::status_t status;

	tds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tds_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.triangle (triangle),
		.cmd      (cmd),
		.status   (status),
		.result   (result),
		.strobe   (strobe)
	);

endmodule

// File: sim/testbench.sv
// Testbench for triangle_depth_sorter: streams batches of triangles and checks
// every sorted word against its own model of the stable depth sort.
// Depends on tds_pkg and the triangle_depth_sorter RTL.
`timescale 1ns / 1ps

module testbench;

	localparam tds_pkg::coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam tds_pkg::coord_t C_MIN = 32'sh8000_0000;
	// Slowest insertion walks the whole store
	localparam int unsigned DRAIN_CYCLES = 2 * tds_pkg::MAX_TRIANGLES + 70;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_ITEMS = 350;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start = 1'b0;
	tds_pkg::tri_in_t  triangle = '0;
	logic              busy;
	tds_pkg::tri_out_t result;
	logic              strobe;

	tds_pkg::tri_in_t  pending_tris[$];
	tds_pkg::tri_out_t due_words[$];

	// Model of the sort store
	tds_pkg::tri_in_t held_tris[tds_pkg::MAX_TRIANGLES];
	longint           held_keys[tds_pkg::MAX_TRIANGLES];
	int unsigned      held_count = 0;
	bit               dropped_seen = 1'b0;

	int unsigned mismatches = 0;
	int unsigned gap_left = 0;
	int unsigned calm_left = 0;
	int unsigned quiet_cycles = 0;

	triangle_depth_sorter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.triangle(triangle),
		.busy   (busy),
		.result (result),
		.strobe (strobe)
	);

	always #5 clk = ~clk;

	// Insert one word in key order after every equal key; emit all on batch end
	function automatic void absorb_triangle(tds_pkg::tri_in_t t);
		longint            key;
		int unsigned       pos;
		tds_pkg::tri_out_t w;
		if (held_count >= tds_pkg::MAX_TRIANGLES) begin
			dropped_seen = 1'b1;
		end else begin
			key = longint'(t.v0_z) + longint'(t.v1_z) + longint'(t.v2_z);
			pos = held_count;
			while (pos > 0 && held_keys[pos-1] > key) begin
				held_tris[pos] = held_tris[pos-1];
				held_keys[pos] = held_keys[pos-1];
				pos--;
			end
			held_tris[pos] = t;
			held_keys[pos] = key;
			held_count++;
		end
		if (t.batch_end) begin
			for (int unsigned k = 0; k < held_count; k++) begin
				w.out_v0_x     = held_tris[k].v0_x;
				w.out_v0_y     = held_tris[k].v0_y;
				w.out_v0_z     = held_tris[k].v0_z;
				w.out_v1_x     = held_tris[k].v1_x;
				w.out_v1_y     = held_tris[k].v1_y;
				w.out_v1_z     = held_tris[k].v1_z;
				w.out_v2_x     = held_tris[k].v2_x;
				w.out_v2_y     = held_tris[k].v2_y;
				w.out_v2_z     = held_tris[k].v2_z;
				w.final_of_run = (k + 1 == held_count);
				w.overflowed   = dropped_seen;
				due_words.push_back(w);
			end
			held_count   = 0;
			dropped_seen = 1'b0;
		end
	endfunction

	function automatic tds_pkg::tri_in_t random_tri(tds_pkg::coord_t z0,
		tds_pkg::coord_t z1, tds_pkg::coord_t z2, logic last);
		tds_pkg::tri_in_t t;
		t.v0_x      = tds_pkg::coord_t'($urandom);
		t.v0_y      = tds_pkg::coord_t'($urandom);
		t.v0_z      = z0;
		t.v1_x      = tds_pkg::coord_t'($urandom);
		t.v1_y      = tds_pkg::coord_t'($urandom);
		t.v1_z      = z1;
		t.v2_x      = tds_pkg::coord_t'($urandom);
		t.v2_y      = tds_pkg::coord_t'($urandom);
		t.v2_z      = z2;
		t.batch_end = last;
		return t;
	endfunction

	function automatic tds_pkg::tri_in_t uniform_tri(tds_pkg::coord_t c, logic last);
		tds_pkg::tri_in_t t;
		t.v0_x      = c;
		t.v0_y      = c;
		t.v0_z      = c;
		t.v1_x      = c;
		t.v1_y      = c;
		t.v1_z      = c;
		t.v2_x      = c;
		t.v2_y      = c;
		t.v2_z      = c;
		t.batch_end = last;
		return t;
	endfunction

	// Flavour 0: any depth; 1: narrow range, so keys tie often; 2: corner values
	function automatic tds_pkg::coord_t draw_depth(int unsigned flavour);
		case (flavour)
			0: return tds_pkg::coord_t'($urandom);
			1: return tds_pkg::coord_t'($urandom_range(0, 6)) - tds_pkg::coord_t'(3);
			default: begin
				case ($urandom_range(0, 3))
					0: return C_MAX;
					1: return C_MIN;
					2: return tds_pkg::coord_t'(0);
					default: return tds_pkg::coord_t'(-1);
				endcase
			end
		endcase
	endfunction

	// Mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: hold the word until taken, then advance after any gap
	always @(posedge clk) begin
		bit taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken)
				absorb_triangle(triangle);
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_tris.size() > 0) begin
					triangle <= pending_tris.pop_front();
					start    <= 1'b1;
					gap_left = draw_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed word must match the oldest one due
	always @(posedge clk) begin
		tds_pkg::tri_out_t want;
		if (arst_n && strobe) begin
			if (due_words.size() == 0) begin
				$error("unexpected word: %h", result);
				mismatches++;
			end else begin
				want = due_words.pop_front();
				check_field("out_v0_x", want.out_v0_x, result.out_v0_x);
				check_field("out_v0_y", want.out_v0_y, result.out_v0_y);
				check_field("out_v0_z", want.out_v0_z, result.out_v0_z);
				check_field("out_v1_x", want.out_v1_x, result.out_v1_x);
				check_field("out_v1_y", want.out_v1_y, result.out_v1_y);
				check_field("out_v1_z", want.out_v1_z, result.out_v1_z);
				check_field("out_v2_x", want.out_v2_x, result.out_v2_x);
				check_field("out_v2_y", want.out_v2_y, result.out_v2_y);
				check_field("out_v2_z", want.out_v2_z, result.out_v2_z);
				check_field("final_of_run", 32'(want.final_of_run), 32'(result.final_of_run));
				check_field("overflowed", 32'(want.overflowed), 32'(result.overflowed));
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned made;
		int unsigned batch_no;
		int unsigned size;
		int unsigned flavour;
		logic        last;

		arst_n = 1'b0;

		// Single-word batches at the key extremes and at zero
		pending_tris.push_back(uniform_tri(C_MAX, 1'b1));
		pending_tris.push_back(uniform_tri(C_MIN, 1'b1));
		pending_tris.push_back(uniform_tri(tds_pkg::coord_t'(0), 1'b1));
		// Extreme keys mixed with ties of key zero and of the minimum key
		pending_tris.push_back(random_tri(0, 0, 0, 1'b0));
		pending_tris.push_back(random_tri(C_MAX, C_MAX, C_MAX, 1'b0));
		pending_tris.push_back(random_tri(C_MIN, C_MIN, C_MIN, 1'b0));
		pending_tris.push_back(random_tri(C_MAX, C_MIN, 1, 1'b0));
		pending_tris.push_back(random_tri(-1, 1, 0, 1'b0));
		pending_tris.push_back(random_tri(-1, 0, 0, 1'b0));
		pending_tris.push_back(random_tri(C_MIN, C_MIN, C_MIN, 1'b0));
		pending_tris.push_back(random_tri(C_MAX, C_MAX, C_MAX - 1, 1'b0));
		pending_tris.push_back(random_tri(0, 0, 0, 1'b1));
		// Falling keys: each new word moves every stored one up
		pending_tris.push_back(random_tri(30, 0, 0, 1'b0));
		pending_tris.push_back(random_tri(20, 0, 0, 1'b0));
		pending_tris.push_back(random_tri(10, 0, 0, 1'b1));

		// Random batches; a full store, and two that overflow it, one of them
		// losing only its batch-end word
		made     = 0;
		batch_no = 0;
		while (made < RANDOM_ITEMS) begin
			case (batch_no)
				3:  size = tds_pkg::MAX_TRIANGLES;
				7:  size = tds_pkg::MAX_TRIANGLES + 1;
				11: size = tds_pkg::MAX_TRIANGLES + 3;
				default: size = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30)
				                                            : $urandom_range(1, 12);
			endcase
			flavour = $urandom_range(0, 2);
			for (int unsigned i = 0; i < size; i++) begin
				last = (i + 1 == size);
				if (batch_no == 3)
					pending_tris.push_back(random_tri(tds_pkg::coord_t'(4000 - 4 * i),
					                                  tds_pkg::coord_t'(i),
					                                  -tds_pkg::coord_t'(i), last));
				else
					pending_tris.push_back(random_tri(draw_depth(flavour), draw_depth(flavour),
					                                  draw_depth(flavour), last));
			end
			made += size;
			batch_no++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_tris.size() == 0 && !start && due_words.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/tds_pkg.sv
rtl/tds_ctrl.sv
rtl/tds_datapath.sv
rtl/triangle_depth_sorter.sv
sim/testbench.sv
